@@ hw/rtl/wcc_pkg.sv @@
// Package: shared constants, types and command/status structs for the co-occurrence counter.
`default_nettype none
package wcc_pkg;
    localparam int VOCAB_SIZE = 1024;
    localparam int TOP_MAX    = 64;
    localparam int WINDOW_MAX = 8;
    localparam int ROW_W  = $clog2(VOCAB_SIZE);
    localparam int COL_W  = $clog2(TOP_MAX);
    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_W = $clog2(WINDOW_MAX + 1);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = VOCAB_SIZE * TOP_MAX;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 40;
    localparam int NORM_W = 16;
    localparam int TOPC_W = 7;
    localparam int WIN_W  = 4;
    localparam int CFG_W  = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX   = '1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'd1;

    typedef enum logic [1:0] {
        KIND_KNOWN    = 2'd0,
        KIND_UNKNOWN  = 2'd1,
        KIND_BOUNDARY = 2'd2,
        KIND_READ     = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD_ISSUE, ST_RD_WAIT, ST_RD_DIV, ST_RD_SQRT, ST_OUT,
        ST_UPD_SLOT, ST_UPD_WAIT, ST_UPD_WRITE
    } state_t;

    typedef struct packed {
        logic clr_step;     // write zero at clear address, advance
        logic latch_in;     // capture input word
        logic ring_clear;
        logic ring_push;
        logic slot_reset;   // slot counter to zero
        logic slot_next;
        logic rd_mem;       // issue matrix read (read addr or update addr)
        logic use_upd_addr;
        logic wr_update;    // write incremented count and sum
        logic div_start;
        logic sqrt_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_read;
        logic is_boundary;
        logic do_count;     // known word below top count
        logic push_valid;
        logic slot_done;    // no more slots to visit
        logic slot_hit;     // current slot is a valid known word
        logic div_done;
        logic sqrt_done;
    } stat_t;
endpackage
`default_nettype wire

@@ hw/rtl/windowed_cooccurrence_counter_top.sv @@
// Top level of the windowed co-occurrence counter.
// s_ channel takes one word per handshake: kind, word_index, column_index.
// Known words below top_count visit each held ring slot; a slot without a valid
// word is skipped and a valid slot gets a read-modify-write of the matrix
// and column sum RAMs (ST_UPD_SLOT read, ST_UPD_WAIT, ST_UPD_WRITE).
// Unknown words, boundaries and uncounted known words return to idle
// straight from ST_RD_ISSUE.
// A read word returns one m_ word after a RAM read, a 32-step restoring
// divider and a 16-step square root; the next word is taken once the
// result has been loaded into the output register.
// One word is in flight at a time; s_ready is high only when the block waits.
// m_ holds its word in an output register until m_ready; a stalled receiver
// holds the next read word at the output stage.
// After reset a clearing pass writes zero into all VOCAB_SIZE*TOP_MAX matrix
// entries and the column sums, one a cycle, with s_ready low;
// configuration writes are taken at any time.
// cfg_we/cfg_index/cfg_data write top_count (0) or window_len (1); a
// window_len write also empties the context ring.
`default_nettype none
module windowed_cooccurrence_counter_top import wcc_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_kind,
    input  wire logic [9:0]           s_word_index,
    input  wire logic [5:0]           s_column_index,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [CNT_W-1:0]          m_entry_count,
    output logic [NORM_W-1:0]         m_norm_value
);
    cmd_t  cmd;
    stat_t stat;

    wcc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd)
    );

    wcc_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_kind(s_kind), .s_word_index(s_word_index),
        .s_column_index(s_column_index), .cmd(cmd), .stat(stat),
        .m_entry_count(m_entry_count), .m_norm_value(m_norm_value)
    );

    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clr_step && cmd.wr_update)) else $error("clear overlaps update");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_entry_count))
        else $error("output word lost");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_update |-> !s_ready) else $error("accept during update");
endmodule
`default_nettype wire

@@ hw/rtl/wcc_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module wcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        if (re) rdata <= mem[addr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/wcc_ctrl.sv @@
// Controller state machine: sequences clearing, word updates and reads.
`default_nettype none
module wcc_ctrl import wcc_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  wire logic  m_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);
    state_t state_reg, state_next;
    logic out_full_reg, out_full_next;
    logic s_fire;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = out_full_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     if (stat.clr_done) state_next = ST_IDLE;
            ST_IDLE:      if (s_fire) state_next = ST_RD_ISSUE;
            ST_RD_ISSUE: begin
                if (stat.is_read) state_next = ST_RD_WAIT;
                else if (stat.is_boundary) state_next = ST_IDLE;
                else if (stat.do_count) state_next = ST_UPD_SLOT;
                else state_next = ST_IDLE;
            end
            ST_RD_WAIT:   state_next = ST_RD_DIV;
            ST_RD_DIV:    if (stat.div_done) state_next = ST_RD_SQRT;
            ST_RD_SQRT:   if (stat.sqrt_done) state_next = ST_OUT;
            ST_OUT:       if (!out_full_reg || m_ready) state_next = ST_IDLE;
            ST_UPD_SLOT: begin
                if (stat.slot_done) state_next = ST_IDLE;
                else if (stat.slot_hit) state_next = ST_UPD_WAIT;
            end
            ST_UPD_WAIT:  state_next = ST_UPD_WRITE;
            ST_UPD_WRITE: state_next = ST_UPD_SLOT;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_CLEAR:    cmd.clr_step = 1'b1;
            ST_IDLE:     cmd.latch_in = s_fire;
            ST_RD_ISSUE: begin
                cmd.slot_reset = 1'b1;
                if (stat.is_read) cmd.rd_mem = 1'b1;
                else if (stat.is_boundary) cmd.ring_clear = 1'b1;
                else if (!stat.do_count) cmd.ring_push = 1'b1;
            end
            ST_RD_WAIT:  cmd.div_start = 1'b1;
            ST_RD_DIV:   cmd.sqrt_start = stat.div_done;
            ST_OUT:      cmd.out_load = !out_full_reg || m_ready;
            ST_UPD_SLOT: begin
                if (stat.slot_done) cmd.ring_push = 1'b1;
                else if (stat.slot_hit) begin
                    cmd.rd_mem = 1'b1;
                    cmd.use_upd_addr = 1'b1;
                end else cmd.slot_next = 1'b1;
            end
            ST_UPD_WAIT: cmd.use_upd_addr = 1'b1;
            ST_UPD_WRITE: begin
                cmd.use_upd_addr = 1'b1;
                cmd.wr_update = 1'b1;
                cmd.slot_next = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    always_comb begin
        out_full_next = out_full_reg;
        if (m_ready) out_full_next = 1'b0;
        if (cmd.out_load) out_full_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            out_full_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/wcc_datapath.sv @@
// Datapath: matrix RAM, column sums, context ring, divider and square root.
`default_nettype none
module wcc_datapath import wcc_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic [1:0]        s_kind,
    input  wire logic [9:0]        s_word_index,
    input  wire logic [5:0]        s_column_index,
    input  wire cmd_t              cmd,
    output stat_t                  stat,
    output logic [CNT_W-1:0]       m_entry_count,
    output logic [NORM_W-1:0]      m_norm_value
);
    logic [TOPC_W-1:0] top_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [1:0]  kind_reg;
    logic [9:0]  word_reg;
    logic [5:0]  col_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic        ring_v_reg [WINDOW_MAX];
    logic [ROW_W-1:0] ring_w_reg [WINDOW_MAX];
    logic [FILL_W-1:0] fill_reg;
    logic [SLOT_W-1:0] wpos_reg;
    logic [FILL_W-1:0] slot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] div_reg;
    logic [63:0] rem_reg;
    logic [31:0] quot_reg;
    logic [5:0]  dstep_reg;
    logic        dbusy_reg;
    logic [4:0]  sstep_reg;
    logic        sbusy_reg;
    logic [15:0] root_reg;
    logic        special_reg;
    logic [15:0] special_val_reg;

    // effective configuration
    logic [FILL_W-1:0] eff_win;
    logic [TOPC_W:0]   eff_top;
    always_comb begin
        if (win_reg == '0) eff_win = FILL_W'(1);
        else if (32'(win_reg) > WINDOW_MAX) eff_win = FILL_W'(WINDOW_MAX);
        else eff_win = FILL_W'(win_reg);
        if (32'(top_reg) > TOP_MAX) eff_top = (TOPC_W+1)'(TOP_MAX);
        else eff_top = {1'b0, top_reg};
    end

    logic in_vocab;
    assign in_vocab = 32'(word_reg) < VOCAB_SIZE;

    assign stat.clr_done    = (32'(clr_addr_reg) == DEPTH - 1);
    assign stat.is_read     = kind_reg == KIND_READ;
    assign stat.is_boundary = kind_reg == KIND_BOUNDARY;
    assign stat.push_valid  = kind_reg == KIND_KNOWN && in_vocab;
    assign stat.do_count    = stat.push_valid && ({1'b0, word_reg} < 11'(eff_top));
    assign stat.slot_done   = (slot_reg >= fill_reg) || (32'(slot_reg) >= WINDOW_MAX);
    logic [SLOT_W-1:0] slot_idx;
    assign slot_idx = slot_reg[SLOT_W-1:0];
    assign stat.slot_hit = ring_v_reg[slot_idx];

    // matrix RAM
    logic [ADDR_W-1:0] ram_addr;
    logic [CNT_W-1:0]  ram_wdata, ram_rdata;
    logic ram_we;
    logic [COL_W-1:0] upd_col;
    assign upd_col = word_reg[COL_W-1:0];
    always_comb begin
        if (cmd.clr_step) ram_addr = clr_addr_reg;
        else if (cmd.use_upd_addr) ram_addr = {ring_w_reg[slot_idx], upd_col};
        else ram_addr = {word_reg[ROW_W-1:0], col_reg[COL_W-1:0]};
    end
    logic inc_ok;
    assign inc_ok    = ram_rdata != COUNT_MAX;
    assign ram_we    = cmd.clr_step || (cmd.wr_update && inc_ok);
    assign ram_wdata = cmd.clr_step ? '0 : ram_rdata + CNT_W'(1);

    wcc_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_matrix (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata),
        .re(cmd.rd_mem), .rdata(ram_rdata)
    );

    // column sums RAM, read alongside the matrix, cleared by the same pass
    logic [COL_W-1:0] sum_addr;
    logic [SUM_W-1:0] sum_wdata, sum_rdata;
    logic sum_we;
    always_comb begin
        if (cmd.clr_step) sum_addr = clr_addr_reg[COL_W-1:0];
        else if (cmd.use_upd_addr) sum_addr = upd_col;
        else sum_addr = col_reg[COL_W-1:0];
    end
    assign sum_we    = cmd.clr_step || (cmd.wr_update && inc_ok && sum_rdata != SUM_MAX);
    assign sum_wdata = cmd.clr_step ? '0 : sum_rdata + SUM_W'(1);

    wcc_ram #(.WIDTH(SUM_W), .DEPTH(TOP_MAX)) u_sums (
        .aclk(aclk), .we(sum_we), .addr(sum_addr), .wdata(sum_wdata),
        .re(cmd.rd_mem), .rdata(sum_rdata)
    );

    logic rd_range;
    assign rd_range = in_vocab && (32'(col_reg) < TOP_MAX);

    logic [CNT_W-1:0] div_cnt;
    logic [SUM_W-1:0] div_den;
    assign div_cnt = rd_range ? ram_rdata : '0;
    assign div_den = (sum_rdata == '0) ? SUM_W'(1) : sum_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg      <= TOPC_W'(64);
            win_reg      <= WIN_W'(8);
            clr_addr_reg <= '0;
            fill_reg     <= '0;
            wpos_reg     <= '0;
            slot_reg     <= '0;
            dbusy_reg    <= 1'b0;
            sbusy_reg    <= 1'b0;
        end else begin
            if (cmd.clr_step) clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (cfg_we && cfg_index == REG_TOP_COUNT) top_reg <= cfg_data[TOPC_W-1:0];
            if (cfg_we && cfg_index == REG_WINDOW_LEN) begin
                win_reg  <= cfg_data[WIN_W-1:0];
                fill_reg <= '0;
                wpos_reg <= '0;
            end
            if (cmd.ring_clear) begin
                fill_reg <= '0;
                wpos_reg <= '0;
            end
            if (cmd.ring_push) begin : push
                logic [SLOT_W-1:0] p;
                p = (FILL_W'(wpos_reg) >= eff_win) ? '0 : wpos_reg;
                ring_v_reg[p] <= stat.push_valid;
                ring_w_reg[p] <= word_reg[ROW_W-1:0];
                wpos_reg <= (FILL_W'(p) + FILL_W'(1) >= eff_win) ? '0 : p + SLOT_W'(1);
                if (fill_reg < eff_win) fill_reg <= fill_reg + FILL_W'(1);
            end
            if (cmd.slot_reset) slot_reg <= '0;
            else if (cmd.slot_next) slot_reg <= slot_reg + FILL_W'(1);
            // restoring divider: (count<<32)/div, 32 quotient bits
            if (cmd.div_start) begin
                dbusy_reg <= 1'b1;
                dstep_reg <= '0;
                rem_reg   <= {32'd0, div_cnt};
                quot_reg  <= '0;
            end else if (dbusy_reg) begin : dv
                logic [64:0] t;
                t = {rem_reg[63:0], 1'b0};
                if (t >= {25'd0, div_reg}) begin
                    rem_reg  <= 64'(t - {25'd0, div_reg});
                    quot_reg <= {quot_reg[30:0], 1'b1};
                end else begin
                    rem_reg  <= t[63:0];
                    quot_reg <= {quot_reg[30:0], 1'b0};
                end
                dstep_reg <= dstep_reg + 6'd1;
                if (dstep_reg == 6'd31) dbusy_reg <= 1'b0;
            end
            // bitwise square root, one bit a cycle
            if (cmd.sqrt_start) begin
                sbusy_reg <= 1'b1;
                sstep_reg <= 5'd15;
                root_reg  <= '0;
            end else if (sbusy_reg) begin : sq
                logic [15:0] tr;
                tr = root_reg | (16'd1 << sstep_reg[3:0]);
                if (32'(tr) * 32'(tr) <= quot_reg) root_reg <= tr;
                sstep_reg <= sstep_reg - 5'd1;
                if (sstep_reg == 5'd0) sbusy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            kind_reg <= s_kind;
            word_reg <= s_word_index;
            col_reg  <= s_column_index;
        end
        if (cmd.div_start) begin
            cnt_reg         <= div_cnt;
            div_reg         <= div_den;
            special_reg     <= (div_cnt == '0) || ({8'd0, div_cnt} >= div_den);
            special_val_reg <= (div_cnt == '0) ? 16'd0 : 16'hFFFF;
        end
        if (cmd.out_load) begin
            m_entry_count <= cnt_reg;
            m_norm_value  <= special_reg ? special_val_reg : root_reg;
        end
    end

    assign stat.div_done  = !dbusy_reg && !cmd.div_start;
    assign stat.sqrt_done = !sbusy_reg && !cmd.sqrt_start;
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Testbench for the windowed co-occurrence counter: queued driver, scoreboard monitor.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wcc_pkg::*;

    localparam int LIMIT = 3000000;
    localparam int SETTLE = 64;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] word;
        logic [5:0] col;
    } word_t;

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [NORM_W-1:0] norm;
    } entry_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_kind = '0;
    logic [9:0] s_word_index = '0;
    logic [5:0] s_column_index = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [CNT_W-1:0] m_entry_count;
    logic [NORM_W-1:0] m_norm_value;

    windowed_cooccurrence_counter_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_word_index(s_word_index), .s_column_index(s_column_index),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_entry_count(m_entry_count), .m_norm_value(m_norm_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow state
    logic [CNT_W-1:0] counts [VOCAB_SIZE*TOP_MAX];
    logic [SUM_W-1:0] col_sum [TOP_MAX];
    logic             slot_ok [WINDOW_MAX];
    logic [9:0]       slot_word [WINDOW_MAX];
    int unsigned      held;
    int unsigned      wpos;
    int unsigned      top_reg;
    int unsigned      win_reg;

    word_t  pend_q[$];
    entry_t entry_q[$];
    int     errors = 0;
    int     cycles = 0;
    logic   quiet = 1'b0;
    logic   fire_in = 1'b0;

    function automatic int unsigned top_eff();
        return top_reg > TOP_MAX ? TOP_MAX : top_reg;
    endfunction

    function automatic int unsigned win_eff();
        if (win_reg == 0) return 1;
        return win_reg > WINDOW_MAX ? WINDOW_MAX : win_reg;
    endfunction

    function automatic logic [NORM_W-1:0] sqrt_ratio(logic [CNT_W-1:0] c, logic [SUM_W-1:0] s);
        logic [63:0] dv, q, t;
        logic [63:0] r;
        dv = (s == 0) ? 64'd1 : {24'd0, s};
        if (c == 0) return '0;
        if ({32'd0, c} >= dv) return 16'hFFFF;
        q = ({32'd0, c} << 32) / dv;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= q) r = t;
        end
        return r[15:0];
    endfunction

    task automatic push_slot(logic ok, logic [9:0] w);
        int unsigned n;
        n = win_eff();
        if (wpos >= n) wpos = 0;
        slot_ok[wpos] = ok;
        slot_word[wpos] = w;
        wpos = (wpos + 1) % n;
        if (held < n) held++;
    endtask

    task automatic count_word(word_t it);
        entry_t e;
        int unsigned a;
        case (kind_t'(it.kind))
            KIND_READ: begin
                e.cnt = counts[{it.word, it.col}];
                e.norm = sqrt_ratio(e.cnt, col_sum[it.col]);
                entry_q.push_back(e);
            end
            KIND_BOUNDARY: begin
                held = 0;
                wpos = 0;
            end
            KIND_UNKNOWN: push_slot(1'b0, '0);
            default: begin
                if (it.word < top_eff()) begin
                    for (int i = 0; i < held && i < WINDOW_MAX; i++) begin
                        if (slot_ok[i]) begin
                            a = {slot_word[i], it.word[5:0]};
                            if (counts[a] != COUNT_MAX) begin
                                counts[a]++;
                                if (col_sum[it.word[5:0]] != SUM_MAX)
                                    col_sum[it.word[5:0]]++;
                            end
                        end
                    end
                end
                push_slot(1'b1, it.word);
            end
        endcase
    endtask

    always @(negedge aclk) begin
        if (!s_valid || fire_in) begin
            if (pend_q.size() != 0 && (quiet || $urandom_range(99) >= 33)) begin
                word_t it;
                it = pend_q.pop_front();
                s_valid <= 1'b1;
                s_kind <= it.kind;
                s_word_index <= it.word;
                s_column_index <= it.col;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= quiet || ($urandom_range(99) >= 33);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        fire_in <= s_valid && s_ready && aresetn;
        if (aresetn && m_valid && m_ready) begin
            if (entry_q.size() == 0) begin
                $error("unexpected result word: count %0d norm %0d",
                       m_entry_count, m_norm_value);
                errors++;
            end else begin
                entry_t e;
                e = entry_q.pop_front();
                if (m_entry_count !== e.cnt) begin
                    $error("entry_count: expected %0d, actual %0d", e.cnt, m_entry_count);
                    errors++;
                end
                if (m_norm_value !== e.norm) begin
                    $error("norm_value: expected %0d, actual %0d", e.norm, m_norm_value);
                    errors++;
                end
            end
        end
        if (aresetn && s_valid && s_ready)
            count_word('{s_kind, s_word_index, s_column_index});
    end

    always @(posedge aclk) begin
        if (cycles >= LIMIT) begin
            $display("** windowed_cooccurrence_counter_top: FAILED **");
            $finish;
        end
    end

    task automatic drain();
        while (pend_q.size() != 0 || s_valid || entry_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[CFG_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_TOP_COUNT) begin
            top_reg = v & 32'h7F;
        end else begin
            win_reg = v & 32'hF;
            held = 0;
            wpos = 0;
        end
    endtask

    function automatic word_t mk(kind_t k, int unsigned w, int unsigned c);
        word_t it;
        it.kind = k;
        it.word = w[9:0];
        it.col = c[5:0];
        return it;
    endfunction

    task automatic random_words(int n);
        int made;
        int len;
        made = 0;
        while (made < n) begin
            len = $urandom_range(12, 1);
            for (int i = 0; i < len; i++) begin
                int unsigned r;
                r = $urandom_range(99);
                if (r < 8)
                    pend_q.push_back(mk(KIND_UNKNOWN, $urandom_range(1023), $urandom_range(63)));
                else if (r < 16)
                    pend_q.push_back(mk(KIND_KNOWN, $urandom_range(1023), $urandom_range(63)));
                else
                    pend_q.push_back(mk(KIND_KNOWN, $urandom_range(15), $urandom_range(63)));
                made++;
            end
            if ($urandom_range(3) == 0) begin
                if ($urandom_range(4) == 0)
                    pend_q.push_back(mk(KIND_READ, $urandom_range(1023), $urandom_range(63)));
                else
                    pend_q.push_back(mk(KIND_READ, $urandom_range(15), $urandom_range(15)));
                made++;
            end
            if ($urandom_range(4) != 0) begin
                pend_q.push_back(mk(KIND_BOUNDARY, $urandom_range(1023), $urandom_range(63)));
                made++;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < VOCAB_SIZE*TOP_MAX; i++) counts[i] = '0;
        for (int i = 0; i < TOP_MAX; i++) col_sum[i] = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            slot_ok[i] = 1'b0;
            slot_word[i] = '0;
        end
        held = 0;
        wpos = 0;
        top_reg = 64;
        win_reg = 8;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: defaults, edge indices, sentence wrap
        pend_q.push_back(mk(KIND_READ, 0, 0));
        pend_q.push_back(mk(KIND_KNOWN, 0, 63));
        pend_q.push_back(mk(KIND_KNOWN, 63, 0));
        pend_q.push_back(mk(KIND_KNOWN, 1023, 0));
        pend_q.push_back(mk(KIND_KNOWN, 64, 0));
        pend_q.push_back(mk(KIND_UNKNOWN, 1023, 63));
        pend_q.push_back(mk(KIND_KNOWN, 0, 0));
        for (int i = 0; i < 9; i++) pend_q.push_back(mk(KIND_KNOWN, i, 0));
        pend_q.push_back(mk(KIND_READ, 0, 63));
        pend_q.push_back(mk(KIND_READ, 63, 0));
        pend_q.push_back(mk(KIND_READ, 1023, 0));
        pend_q.push_back(mk(KIND_READ, 1023, 63));
        pend_q.push_back(mk(KIND_BOUNDARY, 0, 0));
        pend_q.push_back(mk(KIND_KNOWN, 5, 0));
        pend_q.push_back(mk(KIND_READ, 8, 5));
        pend_q.push_back(mk(KIND_READ, 0, 8));
        drain();

        write_reg(REG_TOP_COUNT, 5);
        write_reg(REG_WINDOW_LEN, 3);
        random_words(150);
        drain();

        write_reg(REG_TOP_COUNT, 0);
        write_reg(REG_WINDOW_LEN, 0);
        random_words(120);
        drain();

        write_reg(REG_TOP_COUNT, 127);
        write_reg(REG_WINDOW_LEN, 15);
        random_words(150);
        drain();

        write_reg(REG_TOP_COUNT, 1);
        write_reg(REG_WINDOW_LEN, 1);
        random_words(120);
        drain();

        write_reg(REG_TOP_COUNT, 64);
        write_reg(REG_WINDOW_LEN, 8);
        quiet = 1'b1;
        random_words(150);
        drain();
        quiet = 1'b0;

        write_reg(REG_TOP_COUNT, 12);
        write_reg(REG_WINDOW_LEN, 6);
        random_words(150);
        drain();

        if (errors == 0) begin
            $display("** windowed_cooccurrence_counter_top: PASSED **");
        end else begin
            $display("** windowed_cooccurrence_counter_top: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ windowed_cooccurrence_counter_top.f @@
hw/rtl/wcc_pkg.sv
hw/rtl/wcc_ram.sv
hw/rtl/wcc_ctrl.sv
hw/rtl/wcc_datapath.sv
hw/rtl/windowed_cooccurrence_counter_top.sv
tb/tb.sv
